[sv/lmce_pkg.sv]
package lmce_pkg;

  localparam int CHAR_W = 7;
  localparam int COL_W = 7;
  localparam int STEP_W = 3;

  localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_BSL   = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_LO_B  = 7'h62;
  localparam logic [CHAR_W-1:0] CH_LO_N  = 7'h6E;
  localparam logic [CHAR_W-1:0] CH_LO_T  = 7'h74;
  localparam logic [CHAR_W-1:0] CH_DEL   = 7'h7F;

  localparam logic [COL_W-1:0] WRAP_LIMIT  = 7'd66;
  localparam logic [COL_W-1:0] WRAP_COLUMN = 7'd8;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_NL,
    PRE_ESC,
    PRE_OCT
  } pre_t;

  typedef struct packed {
    logic              wrap;
    pre_t              pre;
    logic              oct_hi;
    logic [2:0]        oct_mid;
    logic [CHAR_W-1:0] final_char;
  } desc_t;

endpackage

[sv/lmce_in_if.sv]
interface lmce_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

[sv/lmce_out_if.sv]
interface lmce_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

[sv/lmce_front.sv]
module lmce_front
  import lmce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  lmce_in_if.sink    in_req,
  input  logic       q_full,
  output logic       push,
  output desc_t      push_desc
);

  logic             list_mode_r;
  logic [COL_W-1:0] column_r, column_nxt;
  logic             lws_r, lws_nxt;
  logic [COL_W-1:0] col_base;
  logic [CHAR_W-1:0] c;

  assign c = in_req.in_char;
  assign in_req.ready = !q_full;
  assign push = in_req.valid && !q_full;

  always_comb begin
    push_desc            = '0;
    push_desc.pre        = PRE_NONE;
    push_desc.final_char = c;
    push_desc.oct_hi     = c[6];
    push_desc.oct_mid    = c[5:3];
    column_nxt           = column_r;
    col_base             = column_r;
    if (list_mode_r) begin
      if (c == CH_LF) begin
        if (lws_r) begin
          push_desc.pre = PRE_NL;
        end
      end else begin
        if (column_r > WRAP_LIMIT) begin
          push_desc.wrap = 1'b1;
          col_base       = WRAP_COLUMN;
        end
        if (c == CH_BS || c == CH_TAB || c == CH_BSL) begin
          push_desc.pre = PRE_ESC;
          if (c == CH_BS) begin
            push_desc.final_char = CH_LO_B;
          end else if (c == CH_TAB) begin
            push_desc.final_char = CH_LO_T;
          end
          column_nxt = col_base + 7'd2;
        end else if (c < CH_SPACE || c == CH_DEL) begin
          push_desc.pre        = PRE_OCT;
          push_desc.final_char = CH_ZERO | {4'b0, c[2:0]};
          column_nxt           = col_base + 7'd4;
        end else begin
          column_nxt = col_base + 7'd1;
        end
      end
    end
    if (push_desc.final_char == CH_LF) begin
      column_nxt = '0;
    end
    lws_nxt = (push_desc.final_char == CH_SPACE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_mode_r <= 1'b0;
      column_r    <= '0;
      lws_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        list_mode_r <= cfg_wdata;
      end
      if (push) begin
        column_r <= column_nxt;
        lws_r    <= lws_nxt;
      end
    end
  end

endmodule

[sv/lmce_queue.sv]
module lmce_queue
  import lmce_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output desc_t head
);

  desc_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[sv/lmce_back.sv]
module lmce_back
  import lmce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  desc_t      head,
  output logic       pop,
  lmce_out_if.source out_req
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic [STEP_W-1:0] wrap_len, pre_len, run_len, j;
  logic [CHAR_W-1:0] ch;
  logic              is_last, emit;

  assign out_req.valid       = out_valid_r;
  assign out_req.out_char    = out_char_r;
  assign out_req.last_of_run = out_last_r;

  always_comb begin
    wrap_len = head.wrap ? 3'd3 : 3'd0;
    unique case (head.pre)
      PRE_NONE: pre_len = 3'd0;
      PRE_NL:   pre_len = 3'd2;
      PRE_ESC:  pre_len = 3'd1;
      PRE_OCT:  pre_len = 3'd3;
      default:  pre_len = 3'd0;
    endcase
    run_len = wrap_len + pre_len + 3'd1;
    j       = step_r - wrap_len;
    ch      = head.final_char;
    if (step_r < wrap_len) begin
      case (step_r[1:0])
        2'd0:    ch = CH_BSL;
        2'd1:    ch = CH_LF;
        default: ch = CH_TAB;
      endcase
    end else if (j < pre_len) begin
      if (j == 3'd0) begin
        ch = CH_BSL;
      end else if (head.pre == PRE_NL) begin
        ch = CH_LO_N;
      end else if (j == 3'd1) begin
        ch = CH_ZERO | {6'b0, head.oct_hi};
      end else begin
        ch = CH_ZERO | {4'b0, head.oct_mid};
      end
    end
    is_last  = (step_r == run_len - 3'd1);
    emit     = !q_empty && (!out_valid_r || out_req.ready);
    pop      = emit && is_last;
    step_nxt = step_r;
    if (emit) begin
      step_nxt = is_last ? '0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= is_last;
    end
  end

endmodule

[sv/list_mode_char_escaper_top.sv]
// List-mode character escaper.
// in_req carries one 7-bit character per request (valid/ready); out_req
// returns its display form one character per request, last_of_run marking
// the final character of each input. cfg_we/cfg_wdata write the list-mode
// bit; write it only while the block is idle.
// With list mode off each character passes through unchanged. With it on,
// control characters except newline, and DEL, become escapes, backslash
// newline tab wraps the line past column 66, and a newline after a space
// gains a visible \n. An accepted input is written into the queue, and its
// first output character is then registered before out_req offers it.
// Throughput while the receiver is ready: one output character per cycle;
// an input that expands to N characters (1 to 7) keeps the sequencer
// until all N are sent, so plain text runs at one character per cycle.
// A two-entry queue sits between the classifying front end and the output
// sequencer; input is taken while the queue has room.
// Reset clears list mode, the column count, the space flag, the queue and
// the output valid flag. When the receiver stalls, the output holds, the
// queue fills and in_req.ready drops.
module list_mode_char_escaper_top
  import lmce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  lmce_in_if.sink    in_req,
  lmce_out_if.source out_req
);

  logic  push, pop, q_full, q_empty;
  desc_t push_desc, head;

  lmce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  lmce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  lmce_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_req (out_req)
  );

endmodule
